FILE: hdl/tccw_pkg.sv
// Package for the text console character writer.
// Holds the sequencer state type, character codes, field widths and defaults.
// No dependencies.
package tccw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned CELL_W     = CHAR_W + COLOR_W;
  localparam int unsigned IDX_W      = 11;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned OUT_W      = 1 + IDX_W + CELL_W + POS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 3;

  localparam logic [CHAR_W-1:0]  CHAR_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0]  CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE     = 8'h20;
  localparam logic [COLOR_W-1:0] COLOR_RESET    = 8'h07;

  // register index, taken from paddr[2]
  localparam logic REG_TEXT_COLOR = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_BASE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_WRITE,
    ST_DONE
  } state_e;

endpackage

FILE: hdl/tccw_cell_ram.sv
// Single-port-write, single-port-read character store with registered read data.
// Used by text_console_char_writer; no package dependencies.
module tccw_cell_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/text_console_char_writer.sv
// Text console character writer: screen character store, cursor and sequencer.
// Depends on tccw_pkg and tccw_cell_ram.
//
// Channel  | Dir | Transaction        | Fields (lsb first)
// s_axis   | in  | one character      | tdata: char_code[7:0]
// m_axis   | out | one result         | tdata: write_enable, cell_index, cell_value,
//          |     |                    |        cursor_position, zero pad
// apb      | in  | register access    | text_color at byte address 0
//
// Steps from acceptance to result: decode, row base, write, result; a newline goes from decode
// to result. A backspace scanning the previous row adds a read and a check state per column
// examined (at most COLUMNS-1), store reads being registered. Then idle takes the next character.
// Reset: a clearing pass writes spaces to all COLUMNS*ROWS cells, one per cycle;
// s_axis_tready stays low until it ends. The result register lets the next
// character be taken while a result waits; the result stage holds if it is still full.
module text_console_char_writer #(
  parameter int unsigned COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tccw_pkg::CHAR_W-1:0]      s_axis_tdata,  // char_code[7:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // write_enable[0], cell_index[11:1], cell_value[27:12], cursor_position[38:28], 0[39]
  output logic [tccw_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tccw_pkg::APB_AW-1:0]      paddr,
  input  logic [tccw_pkg::APB_DW-1:0]      pwdata,
  output logic [tccw_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned PW    = $clog2(CELLS + 1);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned RW    = $clog2(ROWS + 1);
  localparam int unsigned CHW   = tccw_pkg::CHAR_W;
  localparam int unsigned CLW   = tccw_pkg::COLOR_W;
  localparam int unsigned CEW   = tccw_pkg::CELL_W;
  localparam int unsigned IXW   = tccw_pkg::IDX_W;
  localparam int unsigned PSW   = tccw_pkg::POS_W;
  localparam int unsigned TDW   = tccw_pkg::OUT_TDATA_W;
  localparam int unsigned PADW  = TDW - tccw_pkg::OUT_W;

  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_END  = RW'(ROWS);
  localparam logic [AW-1:0] CLR_LAST = AW'(CELLS - 1);

  tccw_pkg::state_e state_q, state_d;

  logic [CLW-1:0] color_q;
  logic [CHW-1:0] char_q, char_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [PW-1:0]  base_q, base_d;
  logic           scan_q, scan_d;
  logic [AW-1:0]  clr_q, clr_d;

  logic           res_we_q, res_we_d;
  logic [PW-1:0]  res_idx_q, res_idx_d;
  logic [CEW-1:0] res_val_q, res_val_d;

  logic           m_valid_q, m_valid_d;
  logic           out_we_q;
  logic [IXW-1:0] out_idx_q;
  logic [CEW-1:0] out_val_q;
  logic [PSW-1:0] out_pos_q;

  logic           out_free;
  logic           out_load;
  logic           in_accept;
  logic [PW-1:0]  mul_prod;
  logic [AW-1:0]  cur_addr;
  logic [CHW-1:0] wr_char;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [CHW-1:0] mem_wdata;
  logic [CHW-1:0] mem_rdata;

  logic           cfg_wr;

  // Configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tccw_pkg::REG_TEXT_COLOR);
  assign prdata = (paddr[2] == tccw_pkg::REG_TEXT_COLOR) ? tccw_pkg::APB_DW'(color_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= tccw_pkg::COLOR_RESET;
    end else if (cfg_wr) begin
      color_q <= pwdata[CLW-1:0];
    end
  end

  // Datapath helpers
  assign mul_prod  = PW'(row_q) * PW'(COLUMNS);
  assign cur_addr  = AW'(base_q + PW'(col_q));
  assign out_free  = !m_valid_q || m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state_q == tccw_pkg::ST_DONE) && out_free;
  assign wr_char   = (char_q == tccw_pkg::CHAR_BACKSPACE) ? tccw_pkg::CHAR_SPACE : char_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tccw_pkg::ST_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          state_d = tccw_pkg::ST_IDLE;
        end
      end
      tccw_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = tccw_pkg::ST_DECODE;
        end
      end
      tccw_pkg::ST_DECODE: begin
        if (char_q == tccw_pkg::CHAR_NEWLINE) begin
          state_d = tccw_pkg::ST_DONE;
        end else begin
          state_d = tccw_pkg::ST_BASE;
        end
      end
      tccw_pkg::ST_BASE: begin
        state_d = scan_q ? tccw_pkg::ST_SCAN_RD : tccw_pkg::ST_WRITE;
      end
      tccw_pkg::ST_SCAN_RD: begin
        state_d = tccw_pkg::ST_SCAN_CHK;
      end
      tccw_pkg::ST_SCAN_CHK: begin
        if (mem_rdata != tccw_pkg::CHAR_SPACE || col_q == CW'(1)) begin
          state_d = tccw_pkg::ST_WRITE;
        end else begin
          state_d = tccw_pkg::ST_SCAN_RD;
        end
      end
      tccw_pkg::ST_WRITE: begin
        state_d = tccw_pkg::ST_DONE;
      end
      tccw_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = tccw_pkg::ST_IDLE;
        end
      end
      default: state_d = tccw_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    char_d    = char_q;
    col_d     = col_q;
    row_d     = row_q;
    base_d    = base_q;
    scan_d    = scan_q;
    clr_d     = clr_q;
    res_we_d  = res_we_q;
    res_idx_d = res_idx_q;
    res_val_d = res_val_q;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = wr_char;
    s_axis_tready = 1'b0;
    unique case (state_q)
      tccw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = tccw_pkg::CHAR_SPACE;
        clr_d     = clr_q + AW'(1);
      end
      tccw_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_accept) begin
          char_d = s_axis_tdata;
        end
      end
      tccw_pkg::ST_DECODE: begin
        res_we_d  = 1'b0;
        res_idx_d = '0;
        res_val_d = '0;
        scan_d    = 1'b0;
        if (char_q == tccw_pkg::CHAR_NEWLINE) begin
          col_d = '0;
          row_d = row_q + RW'(1);
        end else if (char_q == tccw_pkg::CHAR_BACKSPACE) begin
          if (col_q != '0) begin
            col_d = col_q - CW'(1);
          end else if (row_q != '0) begin
            row_d  = row_q - RW'(1);
            col_d  = COL_LAST;
            scan_d = 1'b1;
          end
        end
      end
      tccw_pkg::ST_BASE: begin
        base_d = mul_prod;
      end
      tccw_pkg::ST_SCAN_RD: begin
      end
      tccw_pkg::ST_SCAN_CHK: begin
        if (mem_rdata != tccw_pkg::CHAR_SPACE) begin
          if (col_q != COL_LAST) begin
            col_d = col_q + CW'(1);
          end
        end else begin
          col_d = col_q - CW'(1);
        end
      end
      tccw_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        res_we_d  = 1'b1;
        res_idx_d = PW'(cur_addr);
        res_val_d = {color_q, wr_char};
        if (char_q != tccw_pkg::CHAR_BACKSPACE) begin
          if (col_q == COL_LAST) begin
            col_d = '0;
            row_d = row_q + RW'(1);
          end else begin
            col_d = col_q + CW'(1);
          end
        end
      end
      tccw_pkg::ST_DONE: begin
        if (out_free && row_q >= ROW_END) begin
          row_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tccw_pkg::ST_CLEAR;
      col_q     <= '0;
      row_q     <= '0;
      scan_q    <= 1'b0;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      scan_q    <= scan_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q    <= char_d;
    base_q    <= base_d;
    res_we_q  <= res_we_d;
    res_idx_q <= res_idx_d;
    res_val_q <= res_val_d;
    if (out_load) begin
      out_we_q  <= res_we_q;
      out_idx_q <= IXW'(res_idx_q);
      out_val_q <= res_val_q;
      out_pos_q <= PSW'(mul_prod + PW'(col_q));
    end
  end

  // Result register
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PADW{1'b0}}, out_pos_q, out_val_q, out_idx_q, out_we_q};

  tccw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (CHW)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (cur_addr),
    .rdata_o (mem_rdata)
  );

  // Assertions
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (PW'(mem_waddr) < PW'(CELLS)))
    else $error("cell store write beyond screen");

  a_cursor_legal_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tccw_pkg::ST_IDLE) |-> (row_q < ROW_END && col_q <= COL_LAST))
    else $error("cursor out of screen between characters");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && m_axis_tvalid))
    else $error("pending result overwritten");

  a_scan_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tccw_pkg::ST_SCAN_RD) |-> (col_q != '0 && scan_q))
    else $error("scan reached column zero");

endmodule
